// File: hw/rtl/tls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types, character codes and the type-name matcher of the lexer.
// ----------------------------------------------------------------------------
package tls_pkg;

	typedef enum logic [2:0] {
		KIND_EOF    = 3'd0,
		KIND_SEP    = 3'd1,
		KIND_EQUALS = 3'd2,
		KIND_TYPE   = 3'd3,
		KIND_IDENT  = 3'd4,
		KIND_STRING = 3'd5,
		KIND_INT    = 3'd6
	} kind_t;

	// Progress toward u8 / u16 / u32
	typedef enum logic [2:0] {
		TM_EMPTY = 3'd0,
		TM_U     = 3'd1,
		TM_U1    = 3'd2,
		TM_U3    = 3'd3,
		TM_DONE  = 3'd4,
		TM_FAIL  = 3'd5
	} match_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
	} token_t;

	// One queue entry: the one or two tokens that one item causes
	typedef struct packed {
		logic   two;
		logic   overflow;
		token_t tok0;
		token_t tok1;
	} entry_t;

	localparam int unsigned MAX_SOURCE_BYTES_DFLT = 65536;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [15:0] LEN_LIMIT = 16'hFFFF;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_U     = 8'h75;

	function automatic match_t next_match(input match_t t, input logic [7:0] c);
		match_t r;
		r = TM_FAIL;
		case (t)
			TM_EMPTY: begin
				if (c == CH_U) r = TM_U;
			end
			TM_U: begin
				if (c == CH_EIGHT) r = TM_DONE;
				else if (c == CH_ONE) r = TM_U1;
				else if (c == CH_THREE) r = TM_U3;
			end
			TM_U1: begin
				if (c == CH_SIX) r = TM_DONE;
			end
			TM_U3: begin
				if (c == CH_TWO) r = TM_DONE;
			end
			default: begin
				r = TM_FAIL;
			end
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/tls_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_if
// Valid/ready channels: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface tls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       at_end;

	modport source (output valid, ch, at_end, input ready);
	modport sink (input valid, ch, at_end, output ready);
endinterface

interface tls_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] text_start;
	logic [15:0] text_length;
	logic        overflow;
	logic        last;

	modport source (output valid, token_kind, text_start, text_length, overflow, last,
		input ready);
	modport sink (input valid, token_kind, text_start, text_length, overflow, last,
		output ready);
endinterface

// File: hw/rtl/tls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_front
// Accept bytes, track literal and string state, emit token entries.
// ----------------------------------------------------------------------------
module tls_front #(
	parameter int unsigned MAX_SOURCE_BYTES = tls_pkg::MAX_SOURCE_BYTES_DFLT
) (
	input  logic            clk,
	input  logic            arst_n,
	tls_in_if.sink          chars,
	input  logic            q_full,
	output logic            push,
	output tls_pkg::entry_t push_entry
);

	localparam int unsigned PosCap = (MAX_SOURCE_BYTES > 65536) ? 65536 : MAX_SOURCE_BYTES;
	localparam logic [15:0] PosLimit = 16'(PosCap - 1);

	logic             in_quotes_q, in_quotes_d;
	logic [15:0]      source_pos_q, source_pos_d;
	logic [15:0]      pend_start_q, pend_start_d;
	logic [15:0]      pend_len_q, pend_len_d;
	logic             all_digit_q, all_digit_d;
	tls_pkg::match_t  match_q, match_d;
	logic             ovf_q, ovf_d;

	logic             acc;
	logic             ovf_b;
	logic [15:0]      pos_b;
	logic             has_flush, has_second;
	tls_pkg::token_t  flush_tok, second_tok;
	logic             tok_ovf;
	logic [15:0]      app_start, app_len;
	logic             app_ovf, app_digit;
	tls_pkg::match_t  app_match;
	logic             is_ws;

	assign chars.ready = !q_full;
	assign acc = chars.valid && chars.ready;

	always_comb begin
		// position advance, saturating at the last position
		ovf_b = ovf_q || (source_pos_q == PosLimit);
		pos_b = (source_pos_q == PosLimit) ? source_pos_q : source_pos_q + 16'd1;

		// pending literal as a token
		flush_tok.start  = pend_start_q;
		flush_tok.length = pend_len_q;
		if (match_q == tls_pkg::TM_DONE) flush_tok.kind = tls_pkg::KIND_TYPE;
		else if (all_digit_q) flush_tok.kind = tls_pkg::KIND_INT;
		else flush_tok.kind = tls_pkg::KIND_IDENT;

		// append current byte to the pending text
		app_start = (pend_len_q == 16'd0) ? source_pos_q : pend_start_q;
		app_len   = (pend_len_q == tls_pkg::LEN_LIMIT) ? pend_len_q : pend_len_q + 16'd1;
		app_ovf   = ovf_b || (pend_len_q == tls_pkg::LEN_LIMIT);
		app_digit = all_digit_q && (chars.ch >= tls_pkg::CH_ZERO)
			&& (chars.ch <= tls_pkg::CH_NINE);
		app_match = tls_pkg::next_match(match_q, chars.ch);

		is_ws = chars.ch inside {tls_pkg::CH_SPACE, tls_pkg::CH_TAB, tls_pkg::CH_LF,
			tls_pkg::CH_CR};

		has_flush  = 1'b0;
		has_second = 1'b0;
		second_tok = '{kind: tls_pkg::KIND_EOF, start: source_pos_q, length: 16'd0};
		tok_ovf    = ovf_b;

		in_quotes_d  = in_quotes_q;
		source_pos_d = pos_b;
		pend_start_d = pend_start_q;
		pend_len_d   = pend_len_q;
		all_digit_d  = all_digit_q;
		match_d      = match_q;
		ovf_d        = ovf_b;

		if (chars.at_end) begin
			// flush, then EOF; all state back to reset
			has_flush    = (pend_len_q != 16'd0);
			has_second   = 1'b1;
			tok_ovf      = ovf_q;
			in_quotes_d  = 1'b0;
			source_pos_d = '0;
			pend_start_d = '0;
			pend_len_d   = '0;
			all_digit_d  = 1'b1;
			match_d      = tls_pkg::TM_EMPTY;
			ovf_d        = 1'b0;
		end else if (in_quotes_q && chars.ch == tls_pkg::CH_QUOTE) begin
			has_second        = 1'b1;
			second_tok.kind   = tls_pkg::KIND_STRING;
			second_tok.start  = (pend_len_q != 16'd0) ? pend_start_q : source_pos_q;
			second_tok.length = pend_len_q;
			in_quotes_d  = 1'b0;
			pend_start_d = '0;
			pend_len_d   = '0;
			all_digit_d  = 1'b1;
			match_d      = tls_pkg::TM_EMPTY;
		end else if (in_quotes_q || !(is_ws || chars.ch == tls_pkg::CH_SEMI
				|| chars.ch == tls_pkg::CH_EQ || chars.ch == tls_pkg::CH_QUOTE)) begin
			pend_start_d = app_start;
			pend_len_d   = app_len;
			all_digit_d  = app_digit;
			match_d      = app_match;
			ovf_d        = app_ovf;
		end else begin
			// delimiter outside a string: close the literal
			has_flush    = (pend_len_q != 16'd0);
			pend_start_d = '0;
			pend_len_d   = '0;
			all_digit_d  = 1'b1;
			match_d      = tls_pkg::TM_EMPTY;
			if (chars.ch == tls_pkg::CH_SEMI || chars.ch == tls_pkg::CH_EQ) begin
				has_second        = 1'b1;
				second_tok.kind   = (chars.ch == tls_pkg::CH_SEMI) ? tls_pkg::KIND_SEP
					: tls_pkg::KIND_EQUALS;
				second_tok.start  = source_pos_q;
				second_tok.length = 16'd1;
			end else if (chars.ch == tls_pkg::CH_QUOTE) begin
				in_quotes_d = 1'b1;
			end
		end

		push_entry.two      = has_flush && has_second;
		push_entry.overflow = tok_ovf;
		push_entry.tok0     = has_flush ? flush_tok : second_tok;
		push_entry.tok1     = second_tok;
		push = acc && (has_flush || has_second);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q  <= 1'b0;
			source_pos_q <= '0;
			pend_start_q <= '0;
			pend_len_q   <= '0;
			all_digit_q  <= 1'b1;
			match_q      <= tls_pkg::TM_EMPTY;
			ovf_q        <= 1'b0;
		end else if (acc) begin
			in_quotes_q  <= in_quotes_d;
			source_pos_q <= source_pos_d;
			pend_start_q <= pend_start_d;
			pend_len_q   <= pend_len_d;
			all_digit_q  <= all_digit_d;
			match_q      <= match_d;
			ovf_q        <= ovf_d;
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && chars.at_end) |=> (source_pos_q == 16'd0 && !in_quotes_q && !ovf_q))
		else $error("state not cleared after end mark");
	a_empty_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_len_q == 16'd0) |-> (match_q == tls_pkg::TM_EMPTY && all_digit_q))
		else $error("classifier state without pending text");
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		source_pos_q <= PosLimit)
		else $error("source position beyond limit");
`endif

endmodule

// File: hw/rtl/tls_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_queue
// Short FIFO of token entries between front and back.
// ----------------------------------------------------------------------------
module tls_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tls_pkg::entry_t push_entry,
	output logic            full,
	output logic            head_valid,
	output tls_pkg::entry_t head,
	input  logic            pop
);

	localparam int unsigned Depth = tls_pkg::QUEUE_DEPTH;
	localparam int unsigned PtrW = $clog2(Depth);

	tls_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]   count_q;

	assign full       = (count_q == (PtrW + 1)'(Depth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

// File: hw/rtl/tls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_back
// Unpack entries into single tokens and drive the output register.
// ----------------------------------------------------------------------------
module tls_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  tls_pkg::entry_t head,
	output logic            pop,
	tls_out_if.source       tokens
);

	logic            sel_q;
	logic            out_valid_q;
	tls_pkg::token_t out_tok_q;
	logic            out_ovf_q;
	logic            out_last_q;

	logic            load;
	logic            is_last;
	tls_pkg::token_t cur_tok;

	assign load    = !out_valid_q || tokens.ready;
	assign is_last = !head.two || sel_q;
	assign cur_tok = sel_q ? head.tok1 : head.tok0;
	assign pop     = load && head_valid && is_last;

	assign tokens.valid       = out_valid_q;
	assign tokens.token_kind  = out_tok_q.kind;
	assign tokens.text_start  = out_tok_q.start;
	assign tokens.text_length = out_tok_q.length;
	assign tokens.overflow    = out_ovf_q;
	assign tokens.last        = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) sel_q <= !is_last;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_tok_q  <= cur_tok;
			out_ovf_q  <= head.overflow;
			out_last_q <= is_last;
		end
	end

`ifndef SYNTHESIS
	a_second_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (head_valid && head.two))
		else $error("second token pending without a two-token head");
	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sel_q) |-> (out_valid_q && !out_last_q))
		else $error("second token selected before the first was shown");
`endif

endmodule

// File: hw/rtl/token_lexer_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_lexer_step_top
// Byte-serial lexer: source bytes in, tokens (kind, position, length) out.
// ----------------------------------------------------------------------------
// Usage:
//   chars  : one source byte per item (ch), or an end mark (at_end = 1).
//   tokens : zero, one or two token items per input item; last marks the
//            final token caused by an input item.
// Path: a token reaches tokens through the queue write and then the output
//   register once the item that causes it is accepted.
// Throughput: one input item per cycle while the queue is not full. An item
//   that causes two tokens (literal followed by SEP, EQUALS or EOF) holds the
//   output register for both of its tokens; the four-entry queue absorbs such
//   bursts, so the byte side stalls only when several of them come close together.
// Reset (arst_n low): lexer state clears to position 0, nothing pending,
//   outside a string, overflow cleared; queue and output register empty.
// Receiver stall: the output register holds its token while ready is low;
//   the queue fills, and chars.ready drops once the queue is full.
// The end mark flushes any pending text, emits EOF and clears all state.
// ----------------------------------------------------------------------------
module token_lexer_step_top #(
	parameter int unsigned MAX_SOURCE_BYTES = tls_pkg::MAX_SOURCE_BYTES_DFLT
) (
	input  logic      clk,
	input  logic      arst_n,
	tls_in_if.sink    chars,
	tls_out_if.source tokens
);

	// front -> queue
	logic            push;
	tls_pkg::entry_t push_entry;
	logic            q_full;

	// queue -> back
	logic            head_valid;
	tls_pkg::entry_t head;
	logic            pop;

	// Classify bytes and keep the lexer state; one entry per token-causing item
	tls_front #(
		.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	// Decouple the byte side from the token side
	tls_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	// Split entries into tokens and hold them for the receiver
	tls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.tokens    (tokens)
	);

endmodule
